FILE: rtl/polar_max_height_descriptor_unit_macros.svh
// Assertion helpers for the RTL of the descriptor unit; the back end includes them.
`ifndef POLAR_MAX_HEIGHT_DESCRIPTOR_UNIT_MACROS_SVH
`define POLAR_MAX_HEIGHT_DESCRIPTOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PMHD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define PMHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define PMHD_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PMHD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/pmhd_pkg.sv
`default_nettype none
package pmhd_pkg;

   localparam int RINGS   = 20;
   localparam int SECTORS = 60;
   localparam int NBINS   = RINGS * SECTORS;

   localparam int COORD_W    = 19;
   localparam int RANGE_W    = 18;
   localparam int BIN_W      = 11;
   localparam int RING_W     = 6;
   localparam int SECT_W     = 8;
   localparam int SECT_MUL_W = 41;
   localparam int BIN_CALC_W = 15;
   localparam int D2_W       = 38;
   localparam int MM_W       = 2 * RANGE_W;
   localparam int SCALE_W    = 50;
   localparam int B_W        = 24;
   localparam int BSQ_W      = 2 * B_W;
   localparam int CORDIC_W   = 42;
   localparam int PRESHIFT   = 20;
   localparam int PHI_W      = 35;
   localparam int ITER_N     = 32;
   localparam int ITER_W     = 5;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam int REG_MAX_RANGE = 0;
   localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = RANGE_W'(80000);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic signed [PHI_W-1:0] PHI_QUARTER = 35'sh0_4000_0000;
   localparam logic signed [PHI_W-1:0] PHI_HALF    = 35'sh0_8000_0000;
   localparam logic signed [PHI_W-1:0] PHI_3QUART  = 35'sh0_C000_0000;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_CLEAR = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_READ,
      OP_CLEAR,
      OP_ZERO
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [BIN_W-1:0]           bin;
      logic signed [COORD_W-1:0]  z;
   } work_type;

   typedef enum logic [3:0] {
      F_IDLE, F_SQX, F_SQY, F_MM, F_RANGE, F_RSQ, F_RCMP,
      F_CINIT, F_CITER, F_SECT, F_BIN, F_PUSH
   } fe_state_type;

   typedef enum logic [1:0] {
      B_SWEEP, B_IDLE, B_EXEC
   } be_state_type;

   // Arctangent of 2^-i in units of 2^-32 turn.
   function automatic logic [31:0] step_angle(input logic [ITER_W-1:0] i);
      logic [31:0] a;
      unique case (i)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051E;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2F;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2FA;
         5'd15: a = 32'h0000517D;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A30;
         5'd19: a = 32'h00000518;
         5'd20: a = 32'h0000028C;
         5'd21: a = 32'h00000146;
         5'd22: a = 32'h000000A3;
         5'd23: a = 32'h00000051;
         5'd24: a = 32'h00000029;
         5'd25: a = 32'h00000014;
         5'd26: a = 32'h0000000A;
         5'd27: a = 32'h00000005;
         5'd28: a = 32'h00000003;
         5'd29: a = 32'h00000001;
         5'd30: a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/pmhd_req_if.sv
`default_nettype none
interface pmhd_req_if import pmhd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [1:0]                 func;
   logic signed [COORD_W-1:0]  pos_x;
   logic signed [COORD_W-1:0]  pos_y;
   logic signed [COORD_W-1:0]  pos_z;
   logic [BIN_W-1:0]           read_bin;

   modport source(output valid, func, pos_x, pos_y, pos_z, read_bin, input ready);
   modport sink(input valid, func, pos_x, pos_y, pos_z, read_bin, output ready);
endinterface
`default_nettype wire

FILE: rtl/pmhd_rsp_if.sv
`default_nettype none
interface pmhd_rsp_if import pmhd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  bin_value;
   logic                       bin_occupied;
   logic                       point_accepted;
   logic [BIN_W-1:0]           target_bin;

   modport source(output valid, bin_value, bin_occupied, point_accepted, target_bin,
                  input ready);
   modport sink(input valid, bin_value, bin_occupied, point_accepted, target_bin,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/pmhd_front.sv
`default_nettype none
module pmhd_front import pmhd_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   pmhd_req_if.sink              req,
   input  wire logic [RANGE_W-1:0] max_range,
   input  wire logic             init_busy,
   input  wire logic             q_full,
   output logic                  q_push,
   output work_type              q_data
);

   fe_state_type state_ff, state_in;

   logic signed [COORD_W-1:0]  x_ff, y_ff, z_ff;
   logic [BIN_W-1:0]           bin_ff;
   op_type                     op_ff;
   logic [D2_W-1:0]            xx_ff, d2_ff;
   logic [MM_W-1:0]            mm_ff;
   logic [SCALE_W-1:0]         scaled_ff;
   logic [B_W-1:0]             b_ff;
   logic [BSQ_W-1:0]           bsq_ff;
   logic [RING_W-1:0]          r_ff, ring_ff;
   logic signed [CORDIC_W-1:0] u_ff, v_ff;
   logic signed [PHI_W-1:0]    phi_ff;
   logic [ITER_W-1:0]          it_ff;
   logic [SECT_W-1:0]          sector_ff;

   logic                       accept;
   logic signed [D2_W-1:0]     xsq_w, ysq_w;
   logic                       drop;
   logic                       x_zero, y_zero, x_neg;
   logic signed [CORDIC_W-1:0] xs, ys, du, dv;
   logic signed [PHI_W-1:0]    step;
   logic [31:0]                phi_clamped;
   logic [SECT_MUL_W-1:0]      sprod;
   logic [8:0]                 sect_raw;

   assign accept = req.valid && req.ready;
   assign xsq_w  = x_ff * x_ff;
   assign ysq_w  = y_ff * y_ff;
   assign drop   = d2_ff >= D2_W'(mm_ff);
   assign x_zero = (x_ff == '0);
   assign y_zero = (y_ff == '0);
   assign x_neg  = x_ff[COORD_W-1];
   assign xs     = {{(CORDIC_W-COORD_W-PRESHIFT){x_ff[COORD_W-1]}}, x_ff, PRESHIFT'(0)};
   assign ys     = {{(CORDIC_W-COORD_W-PRESHIFT){y_ff[COORD_W-1]}}, y_ff, PRESHIFT'(0)};
   assign du     = v_ff >>> it_ff;
   assign dv     = u_ff >>> it_ff;
   assign step   = {{(PHI_W-32){1'b0}}, step_angle(it_ff)};

   // Clamp the accumulated angle into one turn before scaling to sectors.
   always_comb begin
      if (phi_ff[PHI_W-1]) begin
         phi_clamped = '0;
      end else if (phi_ff[PHI_W-2:32] != '0) begin
         phi_clamped = '1;
      end else begin
         phi_clamped = phi_ff[31:0];
      end
   end

   assign sprod    = phi_clamped * 9'(SECTORS);
   assign sect_raw = sprod[SECT_MUL_W-1:32];

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = (req.func == FUNC_ADD) ? F_SQX : F_PUSH;
            end
         end
         F_SQX:   state_in = F_SQY;
         F_SQY:   state_in = F_MM;
         F_MM:    state_in = F_RANGE;
         F_RANGE: begin
            if (drop) begin
               state_in = F_PUSH;
            end else if (RINGS > 1) begin
               state_in = F_RSQ;
            end else begin
               state_in = F_CINIT;
            end
         end
         F_RSQ:   state_in = F_RCMP;
         F_RCMP:  state_in = (r_ff == RING_W'(RINGS - 1)) ? F_CINIT : F_RSQ;
         F_CINIT: begin
            if (y_zero && x_neg) begin
               state_in = F_BIN;
            end else if (y_zero || x_zero) begin
               state_in = F_SECT;
            end else begin
               state_in = F_CITER;
            end
         end
         F_CITER: state_in = (it_ff == ITER_W'(ITER_N - 1)) ? F_SECT : F_CITER;
         F_SECT:  state_in = F_BIN;
         F_BIN:   state_in = F_PUSH;
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req.ready = (state_ff == F_IDLE) && !init_busy;
      q_push    = (state_ff == F_PUSH) && !q_full;
      q_data    = '{op: op_ff, bin: bin_ff, z: z_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               x_ff   <= req.pos_x;
               y_ff   <= req.pos_y;
               z_ff   <= req.pos_z;
               bin_ff <= req.read_bin;
               case (req.func)
                  FUNC_ADD:   op_ff <= OP_ADD;
                  FUNC_READ:  op_ff <= OP_READ;
                  FUNC_CLEAR: op_ff <= OP_CLEAR;
                  default:    op_ff <= OP_ZERO;
               endcase
            end
         end
         F_SQX: xx_ff <= xsq_w;
         F_SQY: d2_ff <= xx_ff + ysq_w;
         F_MM:  mm_ff <= max_range * max_range;
         F_RANGE: begin
            if (drop) begin
               op_ff <= OP_ZERO;
            end
            scaled_ff <= SCALE_W'(d2_ff) * SCALE_W'(RINGS * RINGS);
            b_ff      <= B_W'(max_range);
            r_ff      <= RING_W'(1);
            ring_ff   <= '0;
         end
         F_RSQ: bsq_ff <= b_ff * b_ff;
         F_RCMP: begin
            if (SCALE_W'(bsq_ff) <= scaled_ff) begin
               ring_ff <= r_ff;
            end
            b_ff <= b_ff + B_W'(max_range);
            r_ff <= r_ff + RING_W'(1);
         end
         F_CINIT: begin
            it_ff <= '0;
            if (y_zero && x_neg) begin
               sector_ff <= SECT_W'(SECTORS - 1);
            end else if (y_zero) begin
               phi_ff <= PHI_HALF;
            end else if (x_zero) begin
               phi_ff <= y_ff[COORD_W-1] ? PHI_QUARTER : PHI_3QUART;
            end else if (!y_ff[COORD_W-1]) begin
               // Upper half plane: half-turn then quarter-turn pre-rotation.
               u_ff   <= ys;
               v_ff   <= -xs;
               phi_ff <= PHI_3QUART;
            end else begin
               u_ff   <= -ys;
               v_ff   <= xs;
               phi_ff <= PHI_QUARTER;
            end
         end
         F_CITER: begin
            if (!v_ff[CORDIC_W-1]) begin
               u_ff   <= u_ff + du;
               v_ff   <= v_ff - dv;
               phi_ff <= phi_ff + step;
            end else begin
               u_ff   <= u_ff - du;
               v_ff   <= v_ff + dv;
               phi_ff <= phi_ff - step;
            end
            it_ff <= it_ff + ITER_W'(1);
         end
         F_SECT: begin
            sector_ff <= (sect_raw > 9'(SECTORS - 1)) ? SECT_W'(SECTORS - 1)
                                                       : SECT_W'(sect_raw);
         end
         F_BIN: begin
            bin_ff <= BIN_W'(BIN_CALC_W'(ring_ff) * BIN_CALC_W'(SECTORS)
                             + BIN_CALC_W'(sector_ff));
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

FILE: rtl/pmhd_queue.sv
`default_nettype none
module pmhd_queue import pmhd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  push,
   input  work_type   push_data,
   input  wire logic  pop,
   output work_type   head,
   output logic       full,
   output logic       empty
);

   work_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     count_ff, count_in;

   assign full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/pmhd_back.sv
`default_nettype none
`include "polar_max_height_descriptor_unit_macros.svh"
module pmhd_back import pmhd_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  q_empty,
   input  work_type   q_head,
   output logic       q_pop,
   pmhd_rsp_if.source rsp,
   output logic       init_busy
);

   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] height;
   } entry_type;

   entry_type mem [NBINS];

   be_state_type              state_ff, state_in;
   logic [BIN_W-1:0]          sweep_ff;
   logic                      init_ff;
   work_type                  item_ff;
   logic                      inrange_ff;
   entry_type                 rd_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] rsp_value_ff;
   logic                      rsp_occ_ff, rsp_acc_ff;
   logic [BIN_W-1:0]          rsp_bin_ff;

   logic                      head_inrange, sweep_last, load;
   logic                      add_exec, read_hit;
   logic                      wr_en;
   logic [BIN_W-1:0]          wr_addr;
   entry_type                 wr_data;
   logic signed [COORD_W-1:0] new_height;

   assign head_inrange = q_head.bin < BIN_W'(NBINS);
   assign sweep_last   = sweep_ff == BIN_W'(NBINS - 1);
   assign load         = state_ff == B_EXEC;
   assign add_exec     = load && (item_ff.op == OP_ADD);
   assign read_hit     = inrange_ff && rd_ff.valid;
   assign new_height   = (!rd_ff.valid || ($signed(item_ff.z) > $signed(rd_ff.height)))
                         ? item_ff.z : rd_ff.height;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_SWEEP: state_in = sweep_last ? B_IDLE : B_SWEEP;
         B_IDLE:  state_in = q_pop ? B_EXEC : B_IDLE;
         B_EXEC:  state_in = (item_ff.op == OP_CLEAR) ? B_SWEEP : B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = (state_ff == B_IDLE) && !q_empty && (!rsp_valid_ff || rsp.ready);
      init_busy = init_ff;
      wr_en     = (state_ff == B_SWEEP) || add_exec;
      wr_addr   = (state_ff == B_SWEEP) ? sweep_ff : item_ff.bin;
      wr_data   = (state_ff == B_SWEEP) ? entry_type'('0)
                                        : entry_type'{valid: 1'b1, height: new_height};
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_SWEEP;
         sweep_ff     <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == B_SWEEP) begin
            sweep_ff <= sweep_last ? '0 : sweep_ff + 1'b1;
            if (sweep_last) begin
               init_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (q_pop && head_inrange) begin
         rd_ff <= mem[q_head.bin];
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff    <= q_head;
         inrange_ff <= head_inrange;
      end
      if (load) begin
         case (item_ff.op)
            OP_ADD: begin
               rsp_value_ff <= new_height;
               rsp_occ_ff   <= 1'b1;
               rsp_acc_ff   <= 1'b1;
               rsp_bin_ff   <= item_ff.bin;
            end
            OP_READ: begin
               rsp_value_ff <= read_hit ? rd_ff.height : '0;
               rsp_occ_ff   <= read_hit;
               rsp_acc_ff   <= 1'b0;
               rsp_bin_ff   <= item_ff.bin;
            end
            default: begin
               rsp_value_ff <= '0;
               rsp_occ_ff   <= 1'b0;
               rsp_acc_ff   <= 1'b0;
               rsp_bin_ff   <= '0;
            end
         endcase
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.bin_value      = rsp_value_ff;
   assign rsp.bin_occupied   = rsp_occ_ff;
   assign rsp.point_accepted = rsp_acc_ff;
   assign rsp.target_bin     = rsp_bin_ff;

   `PMHD_ASSERT_IMPL(a_exec_out_free, clock, reset, state_ff == B_EXEC, !rsp_valid_ff)
   `PMHD_ASSERT_IMPL(a_init_sweeps, clock, reset, init_ff, state_ff == B_SWEEP)
   `PMHD_ASSERT_NEXT(a_exec_single, clock, reset, state_ff == B_EXEC, state_ff != B_EXEC)
   `PMHD_ASSERT_NEXT(a_add_marks, clock, reset, add_exec, rsp_valid_ff && rsp_occ_ff)

endmodule
`default_nettype wire

FILE: rtl/polar_max_height_descriptor_unit.sv
// Polar max-height descriptor unit: bins signed-millimetre 3D points into a 20 x 60
// ring/sector grid and keeps the highest z per bin. An add item holds the front end
// through the sequential ring search (each boundary is squared in F_RSQ and compared
// in F_RCMP) and the 32-step bearing CORDIC, which handles one item at a time; points
// on an axis skip the CORDIC and dropped points skip both. Read and clear items go
// from the idle state straight to the push state. The bin store is a single-port
// memory; a clear item sweeps all 1200 entries, one per cycle, and after reset the
// same clearing pass runs before the first item is accepted. Configuration writes must
// be made while no item is in flight. Results come from an output register behind
// a two-entry queue, so the front end keeps accepting items while a result waits,
// until the queue is full.
`default_nettype none
module polar_max_height_descriptor_unit import pmhd_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   pmhd_req_if.sink               req_bus,
   pmhd_rsp_if.source             rsp_bus,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0]      csr_prdata,
   output logic                   csr_pready
);

   // The range limit register; the user must write it only while the block is idle (unenforced).
   logic [RANGE_W-1:0] max_range_ff;
   logic               csr_hit, csr_we;

   logic     q_push, q_pop, q_full, q_empty, init_busy;
   work_type q_data, q_head;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[CSR_AW-1:2] == (CSR_AW-2)'(REG_MAX_RANGE);
   assign csr_we     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DW'(max_range_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_range_ff <= MAX_RANGE_RESET;
      end else if (csr_we) begin
         max_range_ff <= csr_pwdata[RANGE_W-1:0];
      end
   end

   // The front end classifies each item and works out the bin of a point.
   pmhd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .max_range (max_range_ff),
      .init_busy (init_busy),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_data)
   );

   // A short queue lets the front end start the next item while the back end
   // waits on the result channel.
   pmhd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The back end owns the bin store and the result register.
   pmhd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp       (rsp_bus),
      .init_busy (init_busy)
   );

endmodule
`default_nettype wire

FILE: test/tb_top.sv
`default_nettype none
module tb_top import pmhd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // One input item and one result item, at the widths of the block's ports.
   typedef struct packed {
      logic signed [COORD_W-1:0] value;
      logic                      occupied;
      logic                      accepted;
      logic [BIN_W-1:0]          bin;
   } grid_result_type;

   typedef struct {
      func_type                  fn;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [BIN_W-1:0]          rbin;
      bit                        typed;   // expected result written in the table
      grid_result_type           typed_result;
   } grid_item_type;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int DRAIN_CYCLES   = 200;

   // Bearing step angles, arctangent of 2^-i in units of 2^-32 turn.
   localparam longint BEARING_STEP [32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
      64'h00000001, 64'h00000000};
   localparam longint TURN = 64'h1_0000_0000;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   pmhd_req_if req_bus();
   pmhd_rsp_if rsp_bus();

   polar_max_height_descriptor_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Shadow copy of the grid and the range register.
   logic signed [COORD_W-1:0] shadow_height [NBINS];
   bit shadow_occupied [NBINS];
   bit ever_written [NBINS];
   int written_bins [$];
   longint range_limit_mm;

   grid_result_type pending_results [$];
   grid_item_type stim_rows [$];
   int error_count;
   int idle_cycles;
   longint cycle_count;

   // Bearing sector of a point: the angle of (-x,-y), found by a 32-step
   // vectoring CORDIC with exact handling of the axis points.
   function automatic int bearing_sector(longint x, longint y);
      longint phi, u, v, t, du, dv;
      longint s;
      if (y == 0 && x < 0) return SECTORS - 1;
      if (y == 0) begin
         phi = TURN / 2;
      end else if (x == 0) begin
         phi = (y > 0) ? 3 * (TURN / 4) : TURN / 4;
      end else begin
         u = -x * (64'sd1 << 20);
         v = -y * (64'sd1 << 20);
         phi = 0;
         if (v < 0) begin
            u = -u;
            v = -v;
            phi = TURN / 2;
         end
         // Quarter turn clockwise before the iterations.
         t = u;
         u = v;
         v = -t;
         phi += TURN / 4;
         for (int i = 0; i < 32; i++) begin
            du = v >>> i;
            dv = u >>> i;
            if (v >= 0) begin
               u += du;
               v -= dv;
               phi += BEARING_STEP[i];
            end else begin
               u -= du;
               v += dv;
               phi -= BEARING_STEP[i];
            end
         end
         if (phi < 0) phi = 0;
         if (phi > TURN - 1) phi = TURN - 1;
      end
      s = (phi * SECTORS) >>> 32;
      if (s > SECTORS - 1) s = SECTORS - 1;
      return int'(s);
   endfunction

   // Applies one accepted item to the shadow grid and returns its result.
   function automatic grid_result_type predict_descriptor(grid_item_type it);
      grid_result_type r;
      longint x, y, z, d2, scaled, b;
      int ring, bin;
      r = '0;
      case (it.fn)
         FUNC_ADD: begin
            x = it.x;
            y = it.y;
            z = it.z;
            d2 = x * x + y * y;
            if (d2 >= range_limit_mm * range_limit_mm) return r;
            scaled = d2 * RINGS * RINGS;
            ring = 0;
            for (int k = 1; k < RINGS; k++) begin
               b = k * range_limit_mm;
               if (b * b <= scaled) ring = k;
            end
            bin = ring * SECTORS + bearing_sector(x, y);
            if (!shadow_occupied[bin] || z > shadow_height[bin])
               shadow_height[bin] = it.z;
            shadow_occupied[bin] = 1'b1;
            if (!ever_written[bin]) begin
               ever_written[bin] = 1'b1;
               written_bins.insert(written_bins.size(), bin);
            end
            r.value = shadow_height[bin];
            r.occupied = 1'b1;
            r.accepted = 1'b1;
            r.bin = BIN_W'(bin);
         end
         FUNC_READ: begin
            r.bin = it.rbin;
            if (it.rbin < NBINS && shadow_occupied[it.rbin]) begin
               r.value = shadow_height[it.rbin];
               r.occupied = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            foreach (shadow_occupied[i]) shadow_occupied[i] = 1'b0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // Drives one item and waits for it to be accepted, then drops valid and
   // adds a random gap now and then so that the sender works in bursts.
   task automatic send_item(grid_item_type it);
      grid_result_type r;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.func <= it.fn;
      req_bus.pos_x <= it.x;
      req_bus.pos_y <= it.y;
      req_bus.pos_z <= it.z;
      req_bus.read_bin <= it.rbin;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      r = predict_descriptor(it);
      if (it.typed && r != it.typed_result)
         $error("table row disagrees with predictor for func %0d", it.fn);
      pending_results.insert(pending_results.size(), it.typed ? it.typed_result : r);
      // The front end leaves its idle state on an accept, so valid can drop at the
      // next falling edge without delaying the next item.
      @(negedge clock);
      req_bus.valid <= 1'b0;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(0, 12)) @(negedge clock);
      end
   endtask

   // Writes one register over the configuration port; the block must be idle.
   task automatic write_range_limit(longint value);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(4 * REG_MAX_RANGE);
      csr_pwdata <= CSR_DW'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      range_limit_mm = value & 64'h3FFFF;
   endtask

   task automatic wait_until_drained();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void add_row(grid_item_type it);
      stim_rows.insert(stim_rows.size(), it);
   endfunction

   function automatic grid_item_type make_item(func_type fn, int x, int y, int z, int rbin);
      grid_item_type it;
      it.fn = fn;
      it.x = COORD_W'(x);
      it.y = COORD_W'(y);
      it.z = COORD_W'(z);
      it.rbin = BIN_W'(rbin);
      it.typed = 1'b0;
      it.typed_result = '0;
      return it;
   endfunction

   function automatic grid_item_type with_result(grid_item_type it, int value, bit occ,
                                                 bit acc, int bin);
      it.typed = 1'b1;
      it.typed_result.value = COORD_W'(value);
      it.typed_result.occupied = occ;
      it.typed_result.accepted = acc;
      it.typed_result.bin = BIN_W'(bin);
      return it;
   endfunction

   // Random item: mostly points inside the current range limit, with reads of
   // bins that have held a point or lie past the grid, and a few clears, idle codes and wild points.
   function automatic grid_item_type random_item();
      grid_item_type it;
      int pick, lim;
      it = make_item(FUNC_ADD, 0, 0, 0, 0);
      it.x = COORD_W'($urandom);
      it.y = COORD_W'($urandom);
      it.z = COORD_W'($urandom);
      it.rbin = BIN_W'($urandom);
      pick = $urandom_range(0, 99);
      lim = (range_limit_mm > 1) ? int'(range_limit_mm) : 1;
      if (pick < 55) begin
         it.x = COORD_W'(int'($urandom_range(0, 2 * lim)) - lim);
         it.y = COORD_W'(int'($urandom_range(0, 2 * lim)) - lim);
         if ($urandom_range(0, 15) == 0) it.y = '0;
         if ($urandom_range(0, 15) == 0) it.x = '0;
      end else if (pick < 65) begin
         // Full coordinate range; most of these fall outside the limit.
      end else if (pick < 95) begin
         it.fn = FUNC_READ;
         if (written_bins.size() != 0 && $urandom_range(0, 9) != 0)
            it.rbin = BIN_W'(written_bins[$urandom_range(0, written_bins.size() - 1)]);
         else
            it.rbin = BIN_W'($urandom_range(NBINS, 2047));
      end else if (pick < 97) begin
         it.fn = FUNC_CLEAR;
      end else begin
         it.fn = FUNC_NONE;
      end
      return it;
   endfunction

   // Receiver: stretches of full readiness alternate with stretches of random stalls.
   always @(negedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count[8])
         rsp_bus.ready <= ($urandom_range(0, 2) != 0);
      else
         rsp_bus.ready <= 1'b1;
   end

   // Result checker and watchdog, both on the rising edge.
   always @(posedge clock) begin
      grid_result_type want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("result item arrived with none expected");
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.bin_value !== want.value) begin
                  $error("bin_value expected %0d actual %0d", want.value, rsp_bus.bin_value);
                  error_count++;
               end
               if (rsp_bus.bin_occupied !== want.occupied) begin
                  $error("bin_occupied expected %0d actual %0d", want.occupied,
                         rsp_bus.bin_occupied);
                  error_count++;
               end
               if (rsp_bus.point_accepted !== want.accepted) begin
                  $error("point_accepted expected %0d actual %0d", want.accepted,
                         rsp_bus.point_accepted);
                  error_count++;
               end
               if (rsp_bus.target_bin !== want.bin) begin
                  $error("target_bin expected %0d actual %0d", want.bin, rsp_bus.target_bin);
                  error_count++;
               end
            end
         end
      end
   end

   // Main sequence: a directed table at the reset range, then random phases
   // at several range limits, with the extremes and a zero limit among them.
   initial begin
      longint phase_limit [6];
      int phase_items [6];
      error_count = 0;
      cycle_count = 0;
      range_limit_mm = 80000;
      foreach (shadow_occupied[i]) begin
         shadow_occupied[i] = 1'b0;
         ever_written[i] = 1'b0;
         shadow_height[i] = '0;
      end
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_NONE;
      req_bus.pos_x = '0;
      req_bus.pos_y = '0;
      req_bus.pos_z = '0;
      req_bus.read_bin = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Out-of-range read after reset: an empty bin that echoes its index.
      add_row(with_result(make_item(FUNC_READ, 0, 0, 0, 2047), 0, 0, 0, 2047));
      add_row(with_result(make_item(FUNC_READ, 0, 0, 0, NBINS), 0, 0, 0, NBINS));
      // The origin sits at a half turn, sector 30 of ring 0.
      add_row(with_result(make_item(FUNC_ADD, 0, 0, -262144, 0), -262144, 1, 1, 30));
      add_row(with_result(make_item(FUNC_ADD, 0, 0, 262143, 0), 262143, 1, 1, 30));
      add_row(with_result(make_item(FUNC_ADD, 0, 0, 5, 0), 262143, 1, 1, 30));
      // Negative x axis lands in the last sector.
      add_row(with_result(make_item(FUNC_ADD, -5, 0, 7, 0), 7, 1, 1, 59));
      // Points at or past the range limit are dropped.
      add_row(with_result(make_item(FUNC_ADD, 80000, 0, 1, 0), 0, 0, 0, 0));
      add_row(with_result(make_item(FUNC_ADD, 262143, 262143, 1, 0), 0, 0, 0, 0));
      add_row(with_result(make_item(FUNC_ADD, -262144, -262144, 1, 0), 0, 0, 0, 0));
      add_row(make_item(FUNC_ADD, 79999, 0, 3, 0));
      add_row(make_item(FUNC_ADD, 0, 79999, 3, 0));
      add_row(make_item(FUNC_ADD, 0, -79999, 3, 0));
      add_row(make_item(FUNC_ADD, -56568, -56568, -9, 0));
      add_row(make_item(FUNC_ADD, 3999, 1, 11, 0));
      add_row(make_item(FUNC_ADD, 4000, -1, 11, 0));
      add_row(make_item(FUNC_ADD, 1, -1, -1, 0));
      add_row(with_result(make_item(FUNC_READ, 0, 0, 0, 30), 262143, 1, 0, 30));
      // The idle func code and a clear both return an all-zero result.
      add_row(with_result(make_item(FUNC_NONE, -1, -1, -1, 2047), 0, 0, 0, 0));
      add_row(with_result(make_item(FUNC_CLEAR, -1, -1, -1, 2047), 0, 0, 0, 0));
      add_row(with_result(make_item(FUNC_READ, 0, 0, 0, 30), 0, 0, 0, 30));
      add_row(with_result(make_item(FUNC_READ, 0, 0, 0, 59), 0, 0, 0, 59));
      add_row(with_result(make_item(FUNC_ADD, 0, 0, -3, 0), -3, 1, 1, 30));
      foreach (stim_rows[i]) send_item(stim_rows[i]);

      // The sender holds off here until every result has come back.
      wait_until_drained();

      phase_limit = '{262143, 1, 0, 5000, 80000, 80000};
      phase_items = '{300, 150, 60, 300, 340, 0};
      for (int p = 0; p < 5; p++) begin
         write_range_limit(phase_limit[p]);
         for (int n = 0; n < phase_items[p]; n++) send_item(random_item());
         wait_until_drained();
      end

      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire
